// ===== rtl/color_space_converter_top_defines.svh =====
// Assertion macros for the color space converter checker.
`ifndef COLOR_SPACE_CONVERTER_TOP_DEFINES_SVH
`define COLOR_SPACE_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CSC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CSC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/csc_pkg.sv =====
// Shared types, widths and matrix coefficients of the color space converter.
`default_nettype none

package csc_pkg;

	localparam int COMP_W  = 24;
	localparam int ALPHA_W = 21;
	localparam int FRAC_W  = 20;
	localparam int ONE_Q20 = 1 << FRAC_W;
	localparam int COEF_W  = 23;
	localparam int OPA_W   = 25;
	localparam int PROD_W  = 49;
	localparam int NUM_W   = 56;
	localparam int DEN_W   = 27;
	localparam int REM_W   = 52;
	localparam int QUO_W   = COMP_W;

	typedef enum logic [1:0] {
		MODE_RGB2XYZ = 2'd0,
		MODE_XYZ2RGB = 2'd1,
		MODE_XYZ2XYY = 2'd2,
		MODE_XYY2XYZ = 2'd3
	} mode_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] comp_first;
		logic signed [COMP_W-1:0] comp_second;
		logic signed [COMP_W-1:0] comp_third;
		logic [ALPHA_W-1:0]       alpha_in;
	} pixel_in_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] res_first;
		logic signed [COMP_W-1:0] res_second;
		logic signed [COMP_W-1:0] res_third;
		logic [ALPHA_W-1:0]       alpha_out;
		logic                     clipped;
	} pixel_out_t;

	// One classified item: offset numerators ready for division.
	typedef struct packed {
		logic [2:0][REM_W-1:0]  num;
		logic [2:0]             ovf_hi;
		logic [2:0]             ovf_lo;
		logic [2:0]             div;
		logic [2:0][COMP_W-1:0] byp;
		logic [DEN_W-1:0]       den2;
		logic [ALPHA_W-1:0]     alpha;
	} job_t;

	// One divider stage.
	typedef struct packed {
		logic [2:0][REM_W-1:0]  rem;
		logic [2:0][QUO_W-1:0]  quo;
		logic [2:0]             ovf_hi;
		logic [2:0]             ovf_lo;
		logic [2:0]             div;
		logic [2:0][COMP_W-1:0] byp;
		logic [DEN_W-1:0]       den2;
		logic [ALPHA_W-1:0]     alpha;
	} div_st_t;

	// Decimal coefficient (times 1e7) to Q20, halves away from zero.
	function automatic logic signed [COEF_W-1:0] coef_q20(input longint tenmil);
		return COEF_W'((tenmil * 64'sd1048576 + 64'sd5000000) / 64'sd10000000);
	endfunction

	localparam logic signed [COEF_W-1:0] TO_XYZ [9] = '{
		coef_q20(4124564), coef_q20(3575761), coef_q20(1804375),
		coef_q20(2126729), coef_q20(7151522), coef_q20(721750),
		coef_q20(193339),  coef_q20(1191920), coef_q20(9503041)
	};

	localparam logic signed [COEF_W-1:0] TO_RGB [9] = '{
		coef_q20(32404542), -coef_q20(15371385), -coef_q20(4985314),
		-coef_q20(9692660), coef_q20(18760108),  coef_q20(415560),
		coef_q20(556434),   -coef_q20(2040259),  coef_q20(10572252)
	};

endpackage

`default_nettype wire

// ===== rtl/csc_queue.sv =====
// Short queue of classified jobs between the front and back parts.
`default_nettype none

module csc_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire csc_pkg::job_t push_data,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output csc_pkg::job_t      pop_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	csc_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push, pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/csc_front.sv =====
// Front part: accepts pixels, selects operands by mode, multiplies and forms numerators.
`default_nettype none

module csc_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire csc_pkg::mode_t     mode,
	input  wire logic               src_valid,
	output logic                    src_ready,
	input  wire csc_pkg::pixel_in_t src_data,
	output logic                    job_valid,
	input  wire logic               job_ready,
	output csc_pkg::job_t           job
);

	localparam int CW = csc_pkg::COMP_W;
	localparam int AW = csc_pkg::OPA_W;
	localparam int PWD = csc_pkg::PROD_W;
	localparam int NW = csc_pkg::NUM_W;
	localparam int DW = csc_pkg::DEN_W;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1: captured word
	csc_pkg::pixel_in_t pix_s1;
	csc_pkg::mode_t     mode_s1;

	// stage 1 operand selection
	logic signed [CW-1:0]   c [3];
	logic signed [CW+1:0]   sum3;
	logic signed [AW-1:0]   zrem;
	logic signed [AW-1:0]   opa [3][3];
	logic signed [CW-1:0]   opb [3][3];
	logic signed [PWD-1:0]  prod [3][3];
	logic [DW-2:0]          den;
	logic [2:0]             div;
	logic [2:0][CW-1:0]     byp;

	// stage 2: products
	logic signed [PWD-1:0]  prod_s2 [3][3];
	logic [DW-2:0]          den_s2;
	logic [2:0]             div_s2;
	logic [2:0][CW-1:0]     byp_s2;
	logic [csc_pkg::ALPHA_W-1:0] alpha_s2;

	logic signed [NW-1:0]   numr [3];

	// stage 3: rounded numerators 2n + d
	logic signed [NW-1:0]   num_s3 [3];
	logic [DW-1:0]          den2_s3;
	logic [2:0]             div_s3;
	logic [2:0][CW-1:0]     byp_s3;
	logic [csc_pkg::ALPHA_W-1:0] alpha_s3;

	logic signed [NW-1:0]   lim;
	logic signed [NW-1:0]   offs [3];

	// stage 4: job ready for the queue
	csc_pkg::job_t job_s4;

	assign en        = !v_s4 || job_ready;
	assign src_ready = en;
	assign job_valid = v_s4;
	assign job       = job_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= src_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		c[0] = pix_s1.comp_first;
		c[1] = pix_s1.comp_second;
		c[2] = pix_s1.comp_third;
		sum3 = (CW+2)'(c[0]) + (CW+2)'(c[1]) + (CW+2)'(c[2]);
		zrem = AW'(csc_pkg::ONE_Q20) - AW'(c[0]) - AW'(c[1]);
		for (int l = 0; l < 3; l++) begin
			for (int k = 0; k < 3; k++) begin
				opa[l][k] = '0;
				opb[l][k] = '0;
			end
		end
		den = (DW-1)'(1);
		div = 3'b000;
		byp = '0;
		unique case (mode_s1)
			csc_pkg::MODE_RGB2XYZ: begin
				for (int l = 0; l < 3; l++) begin
					for (int k = 0; k < 3; k++) begin
						opa[l][k] = AW'(csc_pkg::TO_XYZ[3*l+k]);
						opb[l][k] = c[k];
					end
				end
				den = (DW-1)'(csc_pkg::ONE_Q20);
				div = 3'b111;
			end
			csc_pkg::MODE_XYZ2RGB: begin
				for (int l = 0; l < 3; l++) begin
					for (int k = 0; k < 3; k++) begin
						opa[l][k] = AW'(csc_pkg::TO_RGB[3*l+k]);
						opb[l][k] = c[k];
					end
				end
				den = (DW-1)'(csc_pkg::ONE_Q20);
				div = 3'b111;
			end
			csc_pkg::MODE_XYZ2XYY: begin
				byp[2] = c[1];
				if (sum3 > 0) begin
					opa[0][0] = AW'(csc_pkg::ONE_Q20);
					opb[0][0] = c[0];
					opa[1][0] = AW'(csc_pkg::ONE_Q20);
					opb[1][0] = c[1];
					den = (DW-1)'(sum3);
					div = 3'b011;
				end
			end
			csc_pkg::MODE_XYY2XYZ: begin
				if (c[1] > 0) begin
					opa[0][0] = AW'(c[0]);
					opb[0][0] = c[2];
					opa[2][0] = zrem;
					opb[2][0] = c[2];
					byp[1] = c[2];
					den = (DW-1)'(c[1]);
					div = 3'b101;
				end
			end
		endcase
		for (int l = 0; l < 3; l++) begin
			for (int k = 0; k < 3; k++) begin
				prod[l][k] = opa[l][k] * opb[l][k];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			numr[l] = NW'(prod_s2[l][0]) + NW'(prod_s2[l][1]) + NW'(prod_s2[l][2]);
		end
	end

	// Offset by 2^23 * 2d so an in-range quotient is a plain unsigned 24-bit value.
	always_comb begin
		lim = NW'(den2_s3) << (csc_pkg::QUO_W - 1);
		for (int l = 0; l < 3; l++) begin
			offs[l] = num_s3[l] + lim;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1  <= src_data;
			mode_s1 <= mode;

			prod_s2  <= prod;
			den_s2   <= den;
			div_s2   <= div;
			byp_s2   <= byp;
			alpha_s2 <= pix_s1.alpha_in;

			for (int l = 0; l < 3; l++) begin
				num_s3[l] <= (numr[l] <<< 1) + NW'({1'b0, den_s2});
			end
			den2_s3  <= {den_s2, 1'b0};
			div_s3   <= div_s2;
			byp_s3   <= byp_s2;
			alpha_s3 <= alpha_s2;

			for (int l = 0; l < 3; l++) begin
				job_s4.num[l]    <= csc_pkg::REM_W'(offs[l]);
				job_s4.ovf_hi[l] <= (num_s3[l] >= lim);
				job_s4.ovf_lo[l] <= offs[l][NW-1];
			end
			job_s4.div   <= div_s3;
			job_s4.byp   <= byp_s3;
			job_s4.den2  <= den2_s3;
			job_s4.alpha <= alpha_s3;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/csc_back.sv =====
// Back part: pipelined restoring divider, one quotient bit per stage, then saturation.
`default_nettype none

module csc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	output logic               job_ready,
	input  wire csc_pkg::job_t job,
	output logic               dst_valid,
	input  wire logic          dst_ready,
	output csc_pkg::pixel_out_t dst_data
);

	localparam int QW = csc_pkg::QUO_W;
	localparam int RW = csc_pkg::REM_W;
	localparam int CW = csc_pkg::COMP_W;

	logic                en;
	logic [QW:0]         vld_s;
	csc_pkg::div_st_t    pipe_s [QW+1];
	csc_pkg::div_st_t    nxt [QW];
	logic [RW-1:0]       sub;
	csc_pkg::div_st_t    fin;
	logic [2:0][CW-1:0]  res;
	logic                clip;
	logic                dst_valid_q;
	csc_pkg::pixel_out_t dst_q;

	assign en        = !dst_valid_q || dst_ready;
	assign job_ready = en;
	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_q;
	assign fin       = pipe_s[QW];

	always_comb begin
		sub = '0;
		for (int j = 0; j < QW; j++) begin
			nxt[j] = pipe_s[j];
			for (int l = 0; l < 3; l++) begin
				sub = RW'(pipe_s[j].den2) << (QW - 1 - j);
				if (pipe_s[j].rem[l] >= sub) begin
					nxt[j].rem[l] = pipe_s[j].rem[l] - sub;
					nxt[j].quo[l] = {pipe_s[j].quo[l][QW-2:0], 1'b1};
				end else begin
					nxt[j].quo[l] = {pipe_s[j].quo[l][QW-2:0], 1'b0};
				end
			end
		end
	end

	// Remove the offset, then pick bypass, rail or quotient per lane.
	always_comb begin
		clip = 1'b0;
		for (int l = 0; l < 3; l++) begin
			priority if (!fin.div[l]) begin
				res[l] = fin.byp[l];
			end else if (fin.ovf_hi[l]) begin
				res[l] = {1'b0, {(CW-1){1'b1}}};
				clip   = 1'b1;
			end else if (fin.ovf_lo[l]) begin
				res[l] = {1'b1, {(CW-1){1'b0}}};
				clip   = 1'b1;
			end else begin
				res[l] = {~fin.quo[l][QW-1], fin.quo[l][QW-2:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			dst_valid_q <= 1'b0;
		end else if (en) begin
			vld_s       <= {vld_s[QW-1:0], job_valid};
			dst_valid_q <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0].rem    <= job.num;
			pipe_s[0].quo    <= '0;
			pipe_s[0].ovf_hi <= job.ovf_hi;
			pipe_s[0].ovf_lo <= job.ovf_lo;
			pipe_s[0].div    <= job.div;
			pipe_s[0].byp    <= job.byp;
			pipe_s[0].den2   <= job.den2;
			pipe_s[0].alpha  <= job.alpha;
			for (int j = 0; j < QW; j++) begin
				pipe_s[j+1] <= nxt[j];
			end
			dst_q.res_first  <= res[0];
			dst_q.res_second <= res[1];
			dst_q.res_third  <= res[2];
			dst_q.alpha_out  <= fin.alpha;
			dst_q.clipped    <= clip;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/color_space_converter_top.sv =====
// Top level of the color space converter: mode register, front part, queue, back part.
//
//   channel | handshake              | word
//   --------+------------------------+----------------------------------------
//   src     | src_valid / src_ready  | src_data : csc_pkg::pixel_in_t
//   dst     | dst_valid / dst_ready  | dst_data : csc_pkg::pixel_out_t
//   cfg     | cfg_valid / cfg_ready  | cfg_data : conversion mode, 2 bits
//
// One word per cycle in and out when dst_ready stays high; a word passes through the
// 4 front stages, the queue, 25 divider stages and the output register, in that order.
// Reset clears the mode to rgb-to-xyz and empties every stage.
// A stall on dst holds the back part; the queue then fills and src_ready drops
// once the front part's last stage cannot hand off its word.
`default_nettype none

module color_space_converter_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                src_valid,
	output logic                     src_ready,
	input  wire csc_pkg::pixel_in_t  src_data,
	output logic                     dst_valid,
	input  wire logic                dst_ready,
	output csc_pkg::pixel_out_t      dst_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_data
);

	csc_pkg::mode_t mode_q;
	csc_pkg::job_t  fr_job, bk_job;
	logic           fr_valid, fr_ready, bk_valid, bk_ready;

	// Mode writes must come only while idle; the block itself does not enforce this, and cfg_ready stays high.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= csc_pkg::MODE_RGB2XYZ;
		end else if (cfg_valid) begin
			mode_q <= csc_pkg::mode_t'(cfg_data);
		end
	end

	// Classify and multiply.
	csc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.job_valid (fr_valid),
		.job_ready (fr_ready),
		.job       (fr_job)
	);

	// Decouple front and back so each can stall on its own.
	csc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  (fr_job),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_data   (bk_job)
	);

	// Divide, round and saturate.
	csc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bk_valid),
		.job_ready (bk_ready),
		.job       (bk_job),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data)
	);

endmodule

`default_nettype wire

// ===== rtl/csc_checker.sv =====
// Port-level checks of the color space converter and their binding to the top level.
`default_nettype none

`include "color_space_converter_top_defines.svh"

module csc_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                src_ready,
	input wire logic                dst_valid,
	input wire logic                dst_ready,
	input wire csc_pkg::pixel_out_t dst_data
);

	logic at_rail;

	// Some component sits at the positive or negative Q3.20 rail.
	assign at_rail = dst_data.res_first == 24'h7FFFFF || dst_data.res_first == 24'h800000
		|| dst_data.res_second == 24'h7FFFFF || dst_data.res_second == 24'h800000
		|| dst_data.res_third == 24'h7FFFFF || dst_data.res_third == 24'h800000;

	`CSC_ASSERT_NXT(a_dst_hold, dst_valid && !dst_ready, dst_valid, "dst word dropped while stalled")
	`CSC_ASSERT_IMP(a_clip_rail, dst_valid && dst_data.clipped, at_rail, "clipped with no rail")
	`CSC_ASSERT_IMP(a_backpressure, !src_ready, $past(dst_valid && !dst_ready), "src stall")

endmodule

bind color_space_converter_top csc_checker u_csc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_ready (src_ready),
	.dst_valid (dst_valid),
	.dst_ready (dst_ready),
	.dst_data  (dst_data)
);

`default_nettype wire

// ===== dv/color_space_converter_top_test.sv =====
// Self-checking testbench of the color space converter top level.
`default_nettype none

module color_space_converter_top_test;

	localparam int DRAIN_CYCLES = 40;     // somewhat above the pipeline latency
	localparam int WATCHDOG_MAX = 5000;
	localparam int PHASE_ITEMS  = 190;

	logic                clk;
	logic                arst_n;
	logic                src_valid;
	logic                src_ready;
	csc_pkg::pixel_in_t  src_data;
	logic                dst_valid;
	logic                dst_ready;
	csc_pkg::pixel_out_t dst_data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [1:0]          cfg_data;

	color_space_converter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Pixels waiting for the driver, and converted pixels waiting for the block.
	csc_pkg::pixel_in_t  pixels_to_send[$];
	csc_pkg::pixel_out_t converted_due[$];

	// Shadow of the mode register and the matrix coefficients in Q20.
	csc_pkg::mode_t shadow_mode;
	longint         rgb2xyz_coef[9];
	longint         xyz2rgb_coef[9];

	int  pixels_queued;
	int  pixels_taken;
	int  pixels_returned;
	int  mismatch_count;
	int  quiet_cycles;
	bit  idling_on;
	int  src_gap;
	int  dst_stall;

	// Decimal coefficient times 1e7 into Q20, halves away from zero.
	function automatic longint to_q20(input longint tenmil);
		if (tenmil < 0) begin
			return -((-tenmil * 1048576 + 5000000) / 10000000);
		end
		return (tenmil * 1048576 + 5000000) / 10000000;
	endfunction

	// Round n/d to nearest with ties toward plus infinity, d positive.
	function automatic longint div_round(input longint n, input longint d);
		longint num2;
		longint den2;
		longint q;
		num2 = 2 * n + d;
		den2 = 2 * d;
		q = num2 / den2;
		if ((num2 % den2) != 0 && num2 < 0) begin
			q = q - 1;
		end
		return q;
	endfunction

	// Clamp to the Q3.20 range, flag a clamp.
	function automatic longint clamp_q3_20(input longint v, inout bit hit);
		if (v > 64'sd8388607) begin
			hit = 1'b1;
			return 64'sd8388607;
		end
		if (v < -64'sd8388608) begin
			hit = 1'b1;
			return -64'sd8388608;
		end
		return v;
	endfunction

	// Convert one pixel in the given mode.
	function automatic csc_pkg::pixel_out_t convert_pixel(input csc_pkg::pixel_in_t px,
		input csc_pkg::mode_t m);
		longint c[3];
		longint r[3];
		longint sum;
		longint acc;
		longint coef;
		bit     hit;
		csc_pkg::pixel_out_t o;
		c[0] = longint'(px.comp_first);
		c[1] = longint'(px.comp_second);
		c[2] = longint'(px.comp_third);
		r = '{0, 0, 0};
		hit = 1'b0;
		case (m)
			csc_pkg::MODE_RGB2XYZ, csc_pkg::MODE_XYZ2RGB: begin
				for (int i = 0; i < 3; i++) begin
					acc = 0;
					for (int j = 0; j < 3; j++) begin
						coef = (m == csc_pkg::MODE_RGB2XYZ) ? rgb2xyz_coef[3*i+j]
							: xyz2rgb_coef[3*i+j];
						acc += coef * c[j];
					end
					r[i] = clamp_q3_20(div_round(acc, 1048576), hit);
				end
			end
			csc_pkg::MODE_XYZ2XYY: begin
				sum = c[0] + c[1] + c[2];
				// nonpositive sum leaves chromaticity at zero
				if (sum > 0) begin
					r[0] = clamp_q3_20(div_round(c[0] * 1048576, sum), hit);
					r[1] = clamp_q3_20(div_round(c[1] * 1048576, sum), hit);
				end
				r[2] = c[1];
			end
			default: begin
				// nonpositive y gives black with no clamp
				if (c[1] > 0) begin
					r[0] = clamp_q3_20(div_round(c[0] * c[2], c[1]), hit);
					r[1] = c[2];
					r[2] = clamp_q3_20(div_round((1048576 - c[0] - c[1]) * c[2], c[1]), hit);
				end
			end
		endcase
		o.res_first  = r[0][csc_pkg::COMP_W-1:0];
		o.res_second = r[1][csc_pkg::COMP_W-1:0];
		o.res_third  = r[2][csc_pkg::COMP_W-1:0];
		o.alpha_out  = px.alpha_in;
		o.clipped    = hit;
		return o;
	endfunction

	// Any component: full range, unit range, tiny, or an extreme.
	function automatic logic [csc_pkg::COMP_W-1:0] pick_comp();
		case ($urandom_range(0, 5))
			0, 1: return csc_pkg::COMP_W'($urandom);
			2: return csc_pkg::COMP_W'($urandom_range(0, 1258291));
			3: return csc_pkg::COMP_W'(int'($urandom_range(0, 131072)) - 65536);
			4: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
			default: return csc_pkg::COMP_W'(int'($urandom_range(0, 8)) - 4);
		endcase
	endfunction

	function automatic logic [csc_pkg::ALPHA_W-1:0] pick_alpha();
		if ($urandom_range(0, 3) == 0) begin
			return csc_pkg::ALPHA_W'($urandom);
		end
		return csc_pkg::ALPHA_W'($urandom_range(0, csc_pkg::ONE_Q20));
	endfunction

	// Mostly well-formed colors for the mode, the rest anything at all.
	function automatic csc_pkg::pixel_in_t make_pixel(input csc_pkg::mode_t m);
		csc_pkg::pixel_in_t px;
		px.comp_first  = pick_comp();
		px.comp_second = pick_comp();
		px.comp_third  = pick_comp();
		px.alpha_in    = pick_alpha();
		if ($urandom_range(0, 3) != 0) begin
			if (m == csc_pkg::MODE_XYY2XYZ) begin
				px.comp_first  = csc_pkg::COMP_W'($urandom_range(0, csc_pkg::ONE_Q20));
				// small y now and then to push the quotients out of range
				px.comp_second = $urandom_range(0, 3) == 0
					? csc_pkg::COMP_W'($urandom_range(1, 4096))
					: csc_pkg::COMP_W'($urandom_range(1, csc_pkg::ONE_Q20));
				px.comp_third  = csc_pkg::COMP_W'($urandom_range(0, 1258291));
			end else begin
				px.comp_first  = csc_pkg::COMP_W'($urandom_range(0, 1258291));
				px.comp_second = csc_pkg::COMP_W'($urandom_range(0, 1258291));
				px.comp_third  = csc_pkg::COMP_W'($urandom_range(0, 1258291));
			end
		end
		return px;
	endfunction

	function automatic csc_pkg::pixel_in_t fixed_pixel(input logic [csc_pkg::COMP_W-1:0] a,
		input logic [csc_pkg::COMP_W-1:0] b, input logic [csc_pkg::COMP_W-1:0] c,
		input logic [csc_pkg::ALPHA_W-1:0] al);
		csc_pkg::pixel_in_t px;
		px.comp_first  = a;
		px.comp_second = b;
		px.comp_third  = c;
		px.alpha_in    = al;
		return px;
	endfunction

	// Wait at a falling edge until every queued pixel came back, then let the pipe drain.
	task automatic wait_quiet();
		@(negedge clk);
		while (pixels_taken != pixels_queued || pixels_returned != pixels_taken) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write the mode register through its own channel.
	task automatic write_mode(input csc_pkg::mode_t m);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_pixel(input csc_pkg::pixel_in_t px);
		pixels_to_send.push_back(px);
		pixels_queued++;
	endtask

	// Directed corners of one mode, then random pixels.
	task automatic run_phase(input csc_pkg::mode_t m, input bit with_corners, input int count);
		wait_quiet();
		write_mode(m);
		@(negedge clk);
		if (with_corners) begin
			queue_pixel(fixed_pixel(24'h000000, 24'h000000, 24'h000000, 21'd0));
			queue_pixel(fixed_pixel(24'h7fffff, 24'h7fffff, 24'h7fffff, 21'd1048576));
			queue_pixel(fixed_pixel(24'h800000, 24'h800000, 24'h800000, 21'h1fffff));
			queue_pixel(fixed_pixel(24'h100000, 24'h100000, 24'h100000, 21'h0aaaaa));
			// a nonpositive sum for xyY, a nonpositive y for XYZ from xyY
			queue_pixel(fixed_pixel(24'h050000, 24'hf00000, 24'h040000, 21'h155555));
			if (m == csc_pkg::MODE_XYY2XYZ) begin
				queue_pixel(fixed_pixel(24'h050000, 24'h000001, 24'h100000, 21'd7));
			end
		end
		for (int k = 0; k < count; k++) begin
			queue_pixel(make_pixel(m));
		end
	endtask

	// Clock and reset.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Stimulus: phases that sweep every mode, the extremes 0 and 3 among them.
	initial begin
		for (int i = 0; i < 9; i++) begin
			rgb2xyz_coef[i] = 0;
		end
		rgb2xyz_coef = '{to_q20(4124564), to_q20(3575761), to_q20(1804375),
			to_q20(2126729), to_q20(7151522), to_q20(721750),
			to_q20(193339), to_q20(1191920), to_q20(9503041)};
		xyz2rgb_coef = '{to_q20(32404542), to_q20(-15371385), to_q20(-4985314),
			to_q20(-9692660), to_q20(18760108), to_q20(415560),
			to_q20(556434), to_q20(-2040259), to_q20(10572252)};
		cfg_valid = 1'b0;
		cfg_data  = csc_pkg::MODE_RGB2XYZ;
		idling_on = 1'b1;
		@(posedge arst_n);
		run_phase(csc_pkg::MODE_RGB2XYZ, 1'b1, PHASE_ITEMS);
		run_phase(csc_pkg::MODE_XYZ2RGB, 1'b1, PHASE_ITEMS);
		run_phase(csc_pkg::MODE_XYZ2XYY, 1'b1, PHASE_ITEMS);
		run_phase(csc_pkg::MODE_XYY2XYZ, 1'b1, PHASE_ITEMS);
		run_phase(csc_pkg::MODE_XYZ2XYY, 1'b0, PHASE_ITEMS);
		run_phase(csc_pkg::MODE_RGB2XYZ, 1'b0, PHASE_ITEMS);
		run_phase(csc_pkg::MODE_XYY2XYZ, 1'b0, PHASE_ITEMS);
		wait_quiet();
		// full rate to the end
		idling_on = 1'b0;
		run_phase(csc_pkg::MODE_XYZ2RGB, 1'b0, PHASE_ITEMS);
		wait_quiet();
		if (mismatch_count == 0) begin
			$display("color_space_converter_top: match");
		end else begin
			$display("color_space_converter_top: mismatch");
		end
		$finish;
	end

	// Source driver: present the next pixel once the current word is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_data  <= '0;
			src_gap   = 0;
		end else if (!src_valid || src_ready) begin
			if (src_gap > 0) begin
				src_gap   = src_gap - 1;
				src_valid <= 1'b0;
			end else if (pixels_to_send.size() > 0) begin
				src_data  <= pixels_to_send.pop_front();
				src_valid <= 1'b1;
				if (idling_on && $urandom_range(0, 9) == 0) begin
					src_gap = $urandom_range(1, 19);
				end
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// Sink: stall in bursts while idling is on.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_ready <= 1'b0;
			dst_stall = 0;
		end else if (dst_stall > 0) begin
			dst_stall = dst_stall - 1;
			dst_ready <= 1'b0;
		end else begin
			dst_ready <= 1'b1;
			if (idling_on && $urandom_range(0, 9) == 0) begin
				dst_stall = $urandom_range(1, 19);
			end
		end
	end

	// Monitor: track the mode, predict on each taken pixel, check each returned word.
	initial begin
		shadow_mode     = csc_pkg::MODE_RGB2XYZ;
		pixels_queued   = 0;
		pixels_taken    = 0;
		pixels_returned = 0;
		mismatch_count  = 0;
		quiet_cycles    = 0;
	end

	always @(posedge clk) begin
		csc_pkg::pixel_out_t want;
		if (arst_n) begin
			quiet_cycles = quiet_cycles + 1;
			if (cfg_valid && cfg_ready) begin
				shadow_mode  = csc_pkg::mode_t'(cfg_data);
				quiet_cycles = 0;
			end
			if (src_valid && src_ready) begin
				converted_due.push_back(convert_pixel(src_data, shadow_mode));
				pixels_taken = pixels_taken + 1;
				quiet_cycles = 0;
			end
			if (dst_valid && dst_ready) begin
				quiet_cycles    = 0;
				pixels_returned = pixels_returned + 1;
				if (converted_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("unexpected word %h", dst_data);
					end
				end else begin
					want = converted_due.pop_front();
					if (dst_data.res_first !== want.res_first
						|| dst_data.res_second !== want.res_second
						|| dst_data.res_third !== want.res_third
						|| dst_data.alpha_out !== want.alpha_out
						|| dst_data.clipped !== want.clipped) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("word %0d: expected %h %h %h %h %b, got %h %h %h %h %b",
								pixels_returned, want.res_first, want.res_second,
								want.res_third, want.alpha_out, want.clipped,
								dst_data.res_first, dst_data.res_second,
								dst_data.res_third, dst_data.alpha_out, dst_data.clipped);
						end
					end
				end
			end
			// the drain pause counts toward quiet cycles, well under the limit
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("color_space_converter_top: mismatch");
				$finish;
			end
		end
	end

endmodule

`default_nettype wire
